### hw/rtl/memory_card_serial_protocol_macros.svh
// assertion macros for the memory card serial protocol checker
// no dependencies
`ifndef MEMORY_CARD_SERIAL_PROTOCOL_MACROS_SVH
`define MEMORY_CARD_SERIAL_PROTOCOL_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define MCSP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

### hw/rtl/mcsp_pkg.sv
// types and constants for the memory card serial protocol
// no dependencies
package mcsp_pkg;
  localparam int unsigned SectorBytes = 128;
  localparam int unsigned StoreAw     = 17;

  typedef enum logic [1:0] {
    OP_EXCHANGE = 2'd0,
    OP_DESELECT = 2'd1,
    OP_PRELOAD  = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CMD, PH_ID1, PH_ID2, PH_AMSB, PH_ALSB, PH_RACK1, PH_RACK2,
    PH_RAMSB, PH_RALSB, PH_RDATA, PH_RCHK, PH_REND, PH_RPOST, PH_WDATA,
    PH_WCHK, PH_WACK1, PH_WACK2, PH_WEND, PH_GACK1, PH_GACK2, PH_GDATA
  } phase_e;

  typedef enum logic [2:0] {
    CT_IDLE, CT_READ, CT_EXEC, CT_COPY, CT_COPYEND
  } ctrl_e;

  localparam logic [7:0] CmdAccess = 8'h81;
  localparam logic [7:0] CmdRead   = 8'h52;
  localparam logic [7:0] CmdWrite  = 8'h57;
  localparam logic [7:0] CmdGetId  = 8'h53;
  localparam logic [7:0] RspId1    = 8'h5A;
  localparam logic [7:0] RspId2    = 8'h5D;
  localparam logic [7:0] RspAck1   = 8'h5C;
  localparam logic [7:0] RspGood   = 8'h47;
  localparam logic [7:0] RspBadSum = 8'h4E;
  localparam logic [7:0] FlagReset = 8'h08;
  localparam logic [7:0] FlagNew   = 8'h08;
  localparam logic [7:0] FlagErr   = 8'h04;
  localparam logic [7:0] RspNone   = 8'hFF;

  function automatic logic [7:0] id_byte(input logic [1:0] i);
    logic [7:0] b;
    case (i)
      2'd0:    b = 8'h04;
      2'd3:    b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture request
    logic rd_issue;   // memory read of store
    logic exec;       // run the protocol step, emit result
    logic copy_step;  // one byte of commit
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic commit_req;
    logic copy_done;
  } dp_sts_t;
endpackage

### hw/rtl/mcsp_ctrl.sv
// controller for the memory card serial protocol
// depends on mcsp_pkg
module mcsp_ctrl import mcsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);
  ctrl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CT_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CT_IDLE:    if (start_i) state_d = CT_READ;
      CT_READ:    state_d = CT_EXEC;
      CT_EXEC:    state_d = sts_i.commit_req ? CT_COPY : CT_IDLE;
      CT_COPY:    if (sts_i.copy_done) state_d = CT_COPYEND;
      CT_COPYEND: state_d = CT_IDLE;
      default:    state_d = CT_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      CT_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.latch = start_i;
      end
      CT_READ: cmd_o.rd_issue = 1'b1;
      CT_EXEC: cmd_o.exec = 1'b1;
      CT_COPY: cmd_o.copy_step = 1'b1;
      default: ;
    endcase
  end
endmodule

### hw/rtl/mcsp_dp.sv
// datapath: per-slot protocol registers, staging buffer and card store
// depends on mcsp_pkg
module mcsp_dp import mcsp_pkg::*; #(
  parameter int unsigned NumSectors = 1024,
  parameter int unsigned NumSlots   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [1:0]  card_present_i,
  input  logic [1:0]  op_i,
  input  logic        card_slot_i,
  input  logic [7:0]  tx_byte_i,
  input  logic [16:0] store_address_i,
  output dp_sts_t     sts_o,
  output logic        done_o,
  output logic [7:0]  rx_byte_o,
  output logic        card_busy_o,
  output logic        in_read_data_o
);
  localparam int unsigned SbW = $clog2(SectorBytes);

  phase_e      phase_q [2];
  logic [7:0]  cmd_q   [2];
  logic [7:0]  flag_q  [2];
  logic [15:0] sect_q  [2];
  logic [7:0]  sum_q   [2];
  logic [7:0]  cnt_q   [2];

  logic [1:0]  op_q;
  logic        slot_q;
  logic [7:0]  tx_q;
  logic [16:0] addr_q;

  // card store, one array for both slots
  logic [7:0] store_mem [2*(2**StoreAw)];
  logic [7:0] stage_mem [2*SectorBytes];
  logic [7:0] store_rd_q, stage_rd_q;

  logic [SbW-1:0] copy_idx_q;
  logic [SbW-1:0] copy_wr_idx_q;
  logic           copy_wr_q;
  logic           copy_slot_q;
  logic [15:0]    copy_sect_q;

  phase_e     ph;
  logic       slot_ok, present;
  logic [7:0] cnt_inc;

  assign slot_ok = (NumSlots > 1) || !slot_q;
  assign present = card_present_i[slot_q];
  assign ph      = phase_q[slot_q];
  assign cnt_inc = cnt_q[slot_q] + 8'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_i;
      slot_q <= card_slot_i;
      tx_q   <= tx_byte_i;
      addr_q <= store_address_i;
    end
  end

  logic [StoreAw-1:0] rd_off;
  assign rd_off = {sect_q[slot_q][9:0], cnt_q[slot_q][SbW-1:0]};

  // store: read port and one write port shared by preload and commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue)
      store_rd_q <= store_mem[{slot_q, rd_off}];
    else if (cmd_i.copy_step)
      stage_rd_q <= stage_mem[{copy_slot_q, copy_idx_q}];
    if (copy_wr_q)
      store_mem[{copy_slot_q, copy_sect_q[9:0], copy_wr_idx_q}] <= stage_rd_q;
    else if (cmd_i.exec && slot_ok && op_q == OP_PRELOAD)
      store_mem[{slot_q, addr_q}] <= tx_q;
    if (cmd_i.exec && slot_ok && op_q == OP_EXCHANGE && present && ph == PH_WDATA)
      stage_mem[{slot_q, cnt_q[slot_q][SbW-1:0]}] <= tx_q;
  end

  logic commit_ok;
  assign commit_ok = (tx_q == sum_q[slot_q]) && (sect_q[slot_q] < 16'(NumSectors));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_idx_q    <= '0;
      copy_wr_idx_q <= '0;
      copy_wr_q     <= 1'b0;
      copy_slot_q   <= 1'b0;
      copy_sect_q   <= '0;
    end else begin
      copy_wr_q     <= cmd_i.copy_step;
      copy_wr_idx_q <= copy_idx_q;
      if (cmd_i.exec) begin
        copy_idx_q  <= '0;
        copy_slot_q <= slot_q;
        copy_sect_q <= sect_q[slot_q];
      end else if (cmd_i.copy_step) begin
        copy_idx_q <= copy_idx_q + 1'b1;
      end
    end
  end

  assign sts_o.copy_done  = (copy_idx_q == SbW'(SectorBytes - 1));
  assign sts_o.commit_req = slot_ok && op_q == OP_EXCHANGE && present &&
                            ph == PH_WCHK && commit_ok;

  // protocol step
  phase_e     ph_d;
  logic [7:0] rx_d, cmd_d, flag_d, sum_d, cnt_d;
  logic [15:0] sect_d;

  always_comb begin
    ph_d = ph; rx_d = RspNone; cmd_d = cmd_q[slot_q]; flag_d = flag_q[slot_q];
    sum_d = sum_q[slot_q]; cnt_d = cnt_q[slot_q]; sect_d = sect_q[slot_q];
    unique case (ph)
      PH_IDLE:  if (tx_q == CmdAccess) ph_d = PH_CMD;
      PH_CMD: begin
        rx_d = flag_q[slot_q]; cmd_d = tx_q;
        ph_d = (tx_q == CmdRead || tx_q == CmdWrite || tx_q == CmdGetId) ? PH_ID1 : PH_IDLE;
      end
      PH_ID1: begin rx_d = RspId1; ph_d = PH_ID2; end
      PH_ID2: begin
        rx_d = RspId2;
        ph_d = (cmd_q[slot_q] == CmdGetId) ? PH_GACK1 : PH_AMSB;
      end
      PH_AMSB: begin sect_d = {tx_q, 8'h00}; rx_d = 8'h00; ph_d = PH_ALSB; end
      PH_ALSB: begin
        sect_d = {sect_q[slot_q][15:8], tx_q}; rx_d = 8'h00;
        sum_d  = sect_q[slot_q][15:8] ^ tx_q; cnt_d = 8'h00;
        ph_d   = (cmd_q[slot_q] == CmdRead) ? PH_RACK1 : PH_WDATA;
      end
      PH_RACK1: begin rx_d = RspAck1; ph_d = PH_RACK2; end
      PH_RACK2: begin
        rx_d = RspId2;
        if (sect_q[slot_q] >= 16'(NumSectors)) sect_d = 16'hFFFF;
        ph_d = PH_RAMSB;
      end
      PH_RAMSB: begin rx_d = sect_q[slot_q][15:8]; ph_d = PH_RALSB; end
      PH_RALSB: begin
        rx_d = sect_q[slot_q][7:0];
        ph_d = (sect_q[slot_q] >= 16'(NumSectors)) ? PH_IDLE : PH_RDATA;
      end
      PH_RDATA: begin
        rx_d = store_rd_q; sum_d = sum_q[slot_q] ^ store_rd_q; cnt_d = cnt_inc;
        if (cnt_inc >= 8'(SectorBytes)) ph_d = PH_RCHK;
      end
      PH_RCHK:  begin rx_d = sum_q[slot_q]; ph_d = PH_REND; end
      PH_REND:  begin rx_d = RspGood; ph_d = PH_RPOST; end
      PH_RPOST: ph_d = PH_IDLE;
      PH_WDATA: begin
        sum_d = sum_q[slot_q] ^ tx_q; rx_d = 8'h00; cnt_d = cnt_inc;
        if (cnt_inc >= 8'(SectorBytes)) ph_d = PH_WCHK;
      end
      PH_WCHK: begin
        if (tx_q == sum_q[slot_q]) begin
          if (sect_q[slot_q] < 16'(NumSectors)) flag_d = flag_q[slot_q] & ~FlagNew;
        end else begin
          flag_d = flag_q[slot_q] | FlagErr;
        end
        rx_d = 8'h00; ph_d = PH_WACK1;
      end
      PH_WACK1: begin rx_d = RspAck1; ph_d = PH_WACK2; end
      PH_WACK2: begin rx_d = RspId2; ph_d = PH_WEND; end
      PH_WEND: begin
        if (sect_q[slot_q] >= 16'(NumSectors)) rx_d = RspNone;
        else if ((flag_q[slot_q] & FlagErr) != 8'h00) rx_d = RspBadSum;
        else rx_d = RspGood;
        ph_d = PH_IDLE;
      end
      PH_GACK1: begin rx_d = RspAck1; ph_d = PH_GACK2; end
      PH_GACK2: begin rx_d = RspId2; cnt_d = 8'h00; ph_d = PH_GDATA; end
      PH_GDATA: begin
        rx_d = id_byte(cnt_q[slot_q][1:0]); cnt_d = cnt_inc;
        if (cnt_inc >= 8'd4) ph_d = PH_IDLE;
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  logic       is_exch;
  assign is_exch = cmd_i.exec && slot_ok && op_q == OP_EXCHANGE && present;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        phase_q[s] <= PH_IDLE; cmd_q[s] <= '0; flag_q[s] <= FlagReset;
        sect_q[s] <= '0; sum_q[s] <= '0; cnt_q[s] <= '0;
      end
    end else if (is_exch) begin
      phase_q[slot_q] <= ph_d; cmd_q[slot_q] <= cmd_d; flag_q[slot_q] <= flag_d;
      sect_q[slot_q]  <= sect_d; sum_q[slot_q] <= sum_d; cnt_q[slot_q] <= cnt_d;
    end else if (cmd_i.exec && slot_ok && op_q == OP_DESELECT) begin
      phase_q[slot_q] <= PH_IDLE;
    end
  end

  // result register, one cycle strobe
  phase_e ph_now;
  always_comb begin
    ph_now = ph;
    if (is_exch) ph_now = ph_d;
    else if (op_q == OP_DESELECT) ph_now = PH_IDLE;
  end

  logic       done_q;
  logic [7:0] rx_q;
  logic       busy_q, rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= cmd_i.exec;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rx_q   <= is_exch ? rx_d : RspNone;
      busy_q <= slot_ok && ph_now != PH_IDLE;
      rd_q   <= slot_ok && (ph_now == PH_RDATA || ph_now == PH_RCHK ||
                            ph_now == PH_REND || ph_now == PH_RPOST);
    end
  end
  assign done_o         = done_q;
  assign rx_byte_o      = rx_q;
  assign card_busy_o    = busy_q;
  assign in_read_data_o = rd_q;
endmodule

### hw/rtl/memory_card_serial_protocol.sv
// channel   | handshake            | payload
// config    | card_present_we_i    | card_present_i
// request   | start_i && !busy_o   | op_i card_slot_i tx_byte_i store_address_i
// result    | done_o strobe        | rx_byte_o card_busy_o in_read_data_o
// a request is latched, does a registered store read, then runs its protocol step into the result register
// a good write checksum to an in-range sector adds a byte-by-byte commit through the single store write port
// busy_o stays high until the result strobe and any commit are done
// reset sets phase to idle and flags to FlagReset for both slots; store contents are undefined until preload
// results cannot be stalled
// top level; depends on mcsp_pkg, mcsp_ctrl, mcsp_dp
module memory_card_serial_protocol import mcsp_pkg::*; #(
  parameter int unsigned NumSectors = 1024,
  parameter int unsigned NumSlots   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        card_present_we_i,
  input  logic [1:0]  card_present_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic        card_slot_i,
  input  logic [7:0]  tx_byte_i,
  input  logic [16:0] store_address_i,
  output logic        done_o,
  output logic [7:0]  rx_byte_o,
  output logic        card_busy_o,
  output logic        in_read_data_o
);
  logic [1:0] present_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                present_q <= '0;
    else if (card_present_we_i) present_q <= card_present_i;
  end

  dp_cmd_t cmd;
  dp_sts_t sts;

  mcsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  mcsp_dp #(.NumSectors(NumSectors), .NumSlots(NumSlots)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .card_present_i(present_q),
    .op_i, .card_slot_i, .tx_byte_i, .store_address_i,
    .sts_o(sts), .done_o, .rx_byte_o, .card_busy_o, .in_read_data_o
  );
endmodule

### hw/rtl/mcsp_checker.sv
// port level checks for the memory card serial protocol
// depends on memory_card_serial_protocol_macros.svh
`include "memory_card_serial_protocol_macros.svh"
module mcsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       card_busy_o,
  input logic       in_read_data_o
);
  `MCSP_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "busy missing")
  `MCSP_ASSERT(a_done_latency, clk_i, rst_ni, (start_i && !busy_o) |-> ##3 done_o, "no result")
  `MCSP_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o, "result repeated")
  `MCSP_ASSERT(a_read_busy, clk_i, rst_ni, (done_o && in_read_data_o) |-> card_busy_o, "bad status")
endmodule

bind memory_card_serial_protocol mcsp_checker u_mcsp_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .card_busy_o, .in_read_data_o
);
